// ===== rtl/qlte_pkg.sv =====
// ---------------------------------------------------------------------------
// qlte_pkg: shared types and constants for the quadrant light sensor block
// Command codes, microcode word layout, the control store and field widths.
// ---------------------------------------------------------------------------
`default_nettype none

package qlte_pkg;

    // Field widths
    localparam int unsigned ADC_W  = 10;   // raw reading and calibration width
    localparam int unsigned NORM_W = 10;   // normalized value width
    localparam int unsigned ERR_W  = 12;   // signed error width
    localparam int unsigned TOL_W  = 11;   // tolerance register width
    localparam int unsigned MOVE_W = 2;
    localparam int unsigned FUNC_W = 3;
    localparam int unsigned SEL_W  = 2;
    localparam int unsigned NSENS  = 4;
    localparam int unsigned PROD_W = ADC_W + NORM_W;

    // Calibration constants
    localparam logic [ADC_W-1:0]  ADC_TOP    = '1;
    localparam logic [ADC_W-1:0]  LOW_RESET  = 10'd100;
    localparam logic [ADC_W-1:0]  HIGH_RESET = 10'd900;
    localparam logic [NORM_W-1:0] NORM_SCALE = 10'd1000;
    localparam logic [TOL_W-1:0]  TOL_RESET  = 11'd50;

    // Divider: quotient never exceeds the scale, so NORM_W bits suffice
    localparam int unsigned DIV_STEPS = NORM_W;
    localparam int unsigned BIT_W     = $clog2(DIV_STEPS);

    // Command codes
    localparam logic [FUNC_W-1:0] FUNC_START  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_BRIGHT = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_DARK   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_TRACK  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 3'd4;

    // Move codes
    localparam logic [MOVE_W-1:0] MOVE_NONE = 2'd0;
    localparam logic [MOVE_W-1:0] MOVE_POS  = 2'd1;   // toward top / left
    localparam logic [MOVE_W-1:0] MOVE_NEG  = 2'd2;   // toward bottom / right

    // Configuration register indexes
    localparam logic [0:0] CFG_TOLERANCE = 1'b0;
    localparam logic [0:0] CFG_ENABLE    = 1'b1;

    // Microcode
    localparam int unsigned PC_W = 3;

    typedef enum logic [2:0] {
        OP_IDLE,    // wait for an item, capture it
        OP_CAL,     // apply calibration command, clear sensor counter
        OP_LOAD,    // clamp reading, form numerator and divisor
        OP_MUL,     // scale numerator, seed divider
        OP_DIV,     // one restoring divide step
        OP_STORE,   // keep quotient, advance sensor
        OP_SUMS,    // error sums
        OP_FIN      // build result item
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,      // fall through
        C_NO_ITEM,    // no item accepted this cycle
        C_NOT_TRACK,  // command is not a track step
        C_DIV_BUSY,   // divide steps remain
        C_MORE_SENS,  // sensors remain
        C_OUT_BUSY    // result register still occupied
    } t_cond;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_uword;

    localparam logic [PC_W-1:0] PC_IDLE  = 3'd0;
    localparam logic [PC_W-1:0] PC_CAL   = 3'd1;
    localparam logic [PC_W-1:0] PC_LOAD  = 3'd2;
    localparam logic [PC_W-1:0] PC_MUL   = 3'd3;
    localparam logic [PC_W-1:0] PC_DIV   = 3'd4;
    localparam logic [PC_W-1:0] PC_STORE = 3'd5;
    localparam logic [PC_W-1:0] PC_SUMS  = 3'd6;
    localparam logic [PC_W-1:0] PC_FIN   = 3'd7;   // fall-through wraps to idle

    // Control store
    function automatic t_uword uc_rom(input logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            PC_IDLE:  w = '{op: OP_IDLE,  cond: C_NO_ITEM,   target: PC_IDLE};
            PC_CAL:   w = '{op: OP_CAL,   cond: C_NOT_TRACK, target: PC_FIN};
            PC_LOAD:  w = '{op: OP_LOAD,  cond: C_NEVER,     target: PC_IDLE};
            PC_MUL:   w = '{op: OP_MUL,   cond: C_NEVER,     target: PC_IDLE};
            PC_DIV:   w = '{op: OP_DIV,   cond: C_DIV_BUSY,  target: PC_DIV};
            PC_STORE: w = '{op: OP_STORE, cond: C_MORE_SENS, target: PC_LOAD};
            PC_SUMS:  w = '{op: OP_SUMS,  cond: C_NEVER,     target: PC_IDLE};
            PC_FIN:   w = '{op: OP_FIN,   cond: C_OUT_BUSY,  target: PC_FIN};
            default:  w = '{op: OP_IDLE,  cond: C_NEVER,     target: PC_IDLE};
        endcase
        return w;
    endfunction

    // Result item
    typedef struct packed {
        logic [NORM_W-1:0]        norm_top_left;
        logic [NORM_W-1:0]        norm_top_right;
        logic [NORM_W-1:0]        norm_down_left;
        logic [NORM_W-1:0]        norm_down_right;
        logic signed [ERR_W-1:0]  horiz_error;
        logic signed [ERR_W-1:0]  vert_error;
        logic [MOVE_W-1:0]        vert_move;
        logic [MOVE_W-1:0]        horiz_move;
        logic [ADC_W-1:0]         cal_low_now;
        logic [ADC_W-1:0]         cal_high_now;
    } t_out_item;

endpackage

`default_nettype wire

// ===== rtl/qlte_in_if.sv =====
// ---------------------------------------------------------------------------
// qlte_in_if: command item channel
// Valid/ready channel carrying one command with its readings.
// ---------------------------------------------------------------------------
`default_nettype none

interface qlte_in_if;
    logic                               valid;
    logic                               ready;
    logic [qlte_pkg::FUNC_W-1:0]        func;
    logic [qlte_pkg::SEL_W-1:0]         sensor_index;
    logic [qlte_pkg::ADC_W-1:0]         sample_value;
    logic [qlte_pkg::ADC_W-1:0]         raw_top_left;
    logic [qlte_pkg::ADC_W-1:0]         raw_top_right;
    logic [qlte_pkg::ADC_W-1:0]         raw_down_left;
    logic [qlte_pkg::ADC_W-1:0]         raw_down_right;
    logic [qlte_pkg::ADC_W-1:0]         load_low;
    logic [qlte_pkg::ADC_W-1:0]         load_high;

    modport source (
        output valid, func, sensor_index, sample_value, raw_top_left, raw_top_right,
               raw_down_left, raw_down_right, load_low, load_high,
        input  ready
    );
    modport sink (
        input  valid, func, sensor_index, sample_value, raw_top_left, raw_top_right,
               raw_down_left, raw_down_right, load_low, load_high,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/qlte_out_if.sv =====
// ---------------------------------------------------------------------------
// qlte_out_if: result item channel
// Valid/ready channel carrying normalized values, errors and moves.
// ---------------------------------------------------------------------------
`default_nettype none

interface qlte_out_if;
    logic                                valid;
    logic                                ready;
    logic [qlte_pkg::NORM_W-1:0]         norm_top_left;
    logic [qlte_pkg::NORM_W-1:0]         norm_top_right;
    logic [qlte_pkg::NORM_W-1:0]         norm_down_left;
    logic [qlte_pkg::NORM_W-1:0]         norm_down_right;
    logic signed [qlte_pkg::ERR_W-1:0]   horiz_error;
    logic signed [qlte_pkg::ERR_W-1:0]   vert_error;
    logic [qlte_pkg::MOVE_W-1:0]         vert_move;
    logic [qlte_pkg::MOVE_W-1:0]         horiz_move;
    logic [qlte_pkg::ADC_W-1:0]          cal_low_now;
    logic [qlte_pkg::ADC_W-1:0]          cal_high_now;

    modport source (
        output valid, norm_top_left, norm_top_right, norm_down_left, norm_down_right,
               horiz_error, vert_error, vert_move, horiz_move, cal_low_now, cal_high_now,
        input  ready
    );
    modport sink (
        input  valid, norm_top_left, norm_top_right, norm_down_left, norm_down_right,
               horiz_error, vert_error, vert_move, horiz_move, cal_low_now, cal_high_now,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/quad_ldr_tracking_error.sv =====
// ---------------------------------------------------------------------------
// quad_ldr_tracking_error: four-quadrant light sensor calibration and tracking
// Microcoded sequencer over a small datapath: per-sensor min/max calibration,
// clamp and scale of each reading by a shared radix-2 divider, error sums and
// dead-band move decisions.
// ---------------------------------------------------------------------------
//
//  channel   dir  handshake        carries
//  i_in      in   valid/ready      command, sensor select, readings, load pair
//  o_out     out  valid/ready      normalized values, errors, moves, cal pair
//  i_cfg_*   in   write enable     tolerance (index 0), enable_movement (1)
//
//  A track item runs from acceptance to result through one decode step, then
//  per sensor load, multiply, ten divide steps and store on the single shared
//  divider, then sums and result. Other commands go from decode to result.
//  The next item is taken once the sequencer is back at its idle step, while
//  a previous result may still wait in the output register.
//  Reset is synchronous, active low; calibration returns to 100/900.
// ---------------------------------------------------------------------------
`default_nettype none

module quad_ldr_tracking_error (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    qlte_in_if.sink                      i_in,
    qlte_out_if.source                   o_out,
    input  logic                         i_cfg_we,
    input  logic [0:0]                   i_cfg_idx,
    input  logic [qlte_pkg::TOL_W-1:0]   i_cfg_data
);

    localparam int unsigned AW = qlte_pkg::ADC_W;
    localparam int unsigned NW = qlte_pkg::NORM_W;
    localparam int unsigned EW = qlte_pkg::ERR_W;

    // Sequencer
    logic [qlte_pkg::PC_W-1:0] r_pc, n_pc;
    qlte_pkg::t_uword          uw;
    logic                      jump;

    // Configuration
    logic [qlte_pkg::TOL_W-1:0] r_tol;
    logic                       r_en;

    // Calibration state
    logic [AW-1:0] r_low  [qlte_pkg::NSENS];
    logic [AW-1:0] r_high [qlte_pkg::NSENS];

    // Captured item
    logic [qlte_pkg::FUNC_W-1:0] r_func;
    logic [qlte_pkg::SEL_W-1:0]  r_sel;
    logic [AW-1:0]               r_sample;
    logic [AW-1:0]               r_raw [qlte_pkg::NSENS];
    logic [AW-1:0]               r_ld_lo;
    logic [AW-1:0]               r_ld_hi;

    // Datapath
    logic [qlte_pkg::SEL_W-1:0]  r_k;
    logic [AW-1:0]               r_num;
    logic [AW-1:0]               r_den;
    logic                        r_empty;
    logic [AW-1:0]               r_rem;
    logic [NW-1:0]               r_qd;
    logic [qlte_pkg::BIT_W-1:0]  r_bit;
    logic [NW-1:0]               r_norm [qlte_pkg::NSENS];
    logic signed [EW-1:0]        r_verr;
    logic signed [EW-1:0]        r_herr;

    // Result register
    qlte_pkg::t_out_item r_out;
    logic                r_out_valid;

    logic in_acc, out_acc, out_busy, is_track;
    assign in_acc   = i_in.valid && i_in.ready;
    assign out_acc  = o_out.valid && o_out.ready;
    assign out_busy = r_out_valid && !o_out.ready;
    assign is_track = (r_func == qlte_pkg::FUNC_TRACK);

    // Control word fetch and jump decision
    assign uw = qlte_pkg::uc_rom(r_pc);

    always_comb begin
        unique case (uw.cond)
            qlte_pkg::C_NEVER:     jump = 1'b0;
            qlte_pkg::C_NO_ITEM:   jump = !in_acc;
            qlte_pkg::C_NOT_TRACK: jump = !is_track;
            qlte_pkg::C_DIV_BUSY:  jump = (r_bit != qlte_pkg::BIT_W'(qlte_pkg::DIV_STEPS - 1));
            qlte_pkg::C_MORE_SENS: jump = (r_k != qlte_pkg::SEL_W'(qlte_pkg::NSENS - 1));
            qlte_pkg::C_OUT_BUSY:  jump = out_busy;
            default:               jump = 1'b0;
        endcase
        n_pc = jump ? uw.target : r_pc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= qlte_pkg::PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign i_in.ready = (r_pc == qlte_pkg::PC_IDLE);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= qlte_pkg::TOL_RESET;
            r_en  <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                qlte_pkg::CFG_TOLERANCE: r_tol <= i_cfg_data;
                qlte_pkg::CFG_ENABLE:    r_en  <= i_cfg_data[0];
                default:                 r_tol <= r_tol;
            endcase
        end
    end

    // Clamp and range of the current sensor
    logic [AW-1:0] cur_lo, cur_hi, cur_raw, clamped;
    assign cur_lo  = r_low[r_k];
    assign cur_hi  = r_high[r_k];
    assign cur_raw = r_raw[r_k];
    assign clamped = (cur_raw < cur_lo) ? cur_lo : ((cur_raw > cur_hi) ? cur_hi : cur_raw);

    // Scaling product
    logic [qlte_pkg::PROD_W-1:0] prod;
    assign prod = {{NW{1'b0}}, r_num} * {{AW{1'b0}}, qlte_pkg::NORM_SCALE};

    // One restoring divide step
    logic [AW:0] trial;
    logic        qbit;
    assign trial = {r_rem, r_qd[NW-1]};
    assign qbit  = (trial >= {1'b0, r_den});

    // Error sums
    logic [NW:0] s_top, s_down, s_left, s_right;
    assign s_top   = {1'b0, r_norm[0]} + {1'b0, r_norm[1]};
    assign s_down  = {1'b0, r_norm[2]} + {1'b0, r_norm[3]};
    assign s_left  = {1'b0, r_norm[0]} + {1'b0, r_norm[2]};
    assign s_right = {1'b0, r_norm[1]} + {1'b0, r_norm[3]};

    // Dead-band decisions
    logic [EW-1:0]                 v_mag, h_mag;
    logic [qlte_pkg::MOVE_W-1:0]   v_move, h_move;
    always_comb begin
        v_mag = r_verr[EW-1] ? EW'(-r_verr) : EW'(r_verr);
        h_mag = r_herr[EW-1] ? EW'(-r_herr) : EW'(r_herr);
        v_move = qlte_pkg::MOVE_NONE;
        h_move = qlte_pkg::MOVE_NONE;
        if (r_en && is_track && v_mag > EW'(r_tol)) begin
            v_move = r_verr[EW-1] ? qlte_pkg::MOVE_NEG : qlte_pkg::MOVE_POS;
        end
        if (r_en && is_track && h_mag > EW'(r_tol)) begin
            h_move = r_herr[EW-1] ? qlte_pkg::MOVE_NEG : qlte_pkg::MOVE_POS;
        end
    end

    // Calibration state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < qlte_pkg::NSENS; i++) begin
                r_low[i]  <= qlte_pkg::LOW_RESET;
                r_high[i] <= qlte_pkg::HIGH_RESET;
            end
        end else if (uw.op == qlte_pkg::OP_CAL) begin
            case (r_func)
                qlte_pkg::FUNC_START: begin
                    for (int i = 0; i < qlte_pkg::NSENS; i++) begin
                        r_low[i]  <= qlte_pkg::ADC_TOP;
                        r_high[i] <= '0;
                    end
                end
                qlte_pkg::FUNC_BRIGHT: begin
                    if (r_sample > r_high[r_sel]) r_high[r_sel] <= r_sample;
                end
                qlte_pkg::FUNC_DARK: begin
                    if (r_sample < r_low[r_sel]) r_low[r_sel] <= r_sample;
                end
                qlte_pkg::FUNC_LOAD: begin
                    r_low[r_sel]  <= r_ld_lo;
                    r_high[r_sel] <= r_ld_hi;
                end
                default: begin
                end
            endcase
        end
    end

    // Item capture and datapath registers
    always_ff @(posedge i_clk) begin
        case (uw.op)
            qlte_pkg::OP_IDLE: begin
                if (in_acc) begin
                    r_func   <= i_in.func;
                    r_sel    <= i_in.sensor_index;
                    r_sample <= i_in.sample_value;
                    r_raw[0] <= i_in.raw_top_left;
                    r_raw[1] <= i_in.raw_top_right;
                    r_raw[2] <= i_in.raw_down_left;
                    r_raw[3] <= i_in.raw_down_right;
                    r_ld_lo  <= i_in.load_low;
                    r_ld_hi  <= i_in.load_high;
                end
            end
            qlte_pkg::OP_CAL: begin
                r_k <= '0;
            end
            qlte_pkg::OP_LOAD: begin
                r_empty <= (cur_hi <= cur_lo);
                r_num   <= clamped - cur_lo;
                r_den   <= cur_hi - cur_lo;
            end
            qlte_pkg::OP_MUL: begin
                // quotient fits NW bits, so the upper half is already below the divisor
                r_rem <= prod[qlte_pkg::PROD_W-1:NW];
                r_qd  <= prod[NW-1:0];
                r_bit <= '0;
            end
            qlte_pkg::OP_DIV: begin
                r_rem <= qbit ? AW'(trial - {1'b0, r_den}) : AW'(trial);
                r_qd  <= {r_qd[NW-2:0], qbit};
                r_bit <= r_bit + 1'b1;
            end
            qlte_pkg::OP_STORE: begin
                r_norm[r_k] <= r_empty ? '0 : r_qd;
                r_k         <= r_k + 1'b1;
            end
            qlte_pkg::OP_SUMS: begin
                r_verr <= $signed({1'b0, s_top})  - $signed({1'b0, s_down});
                r_herr <= $signed({1'b0, s_left}) - $signed({1'b0, s_right});
            end
            default: begin
            end
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (uw.op == qlte_pkg::OP_FIN && !out_busy) begin
            r_out_valid <= 1'b1;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.op == qlte_pkg::OP_FIN && !out_busy) begin
            r_out.norm_top_left   <= is_track ? r_norm[0] : '0;
            r_out.norm_top_right  <= is_track ? r_norm[1] : '0;
            r_out.norm_down_left  <= is_track ? r_norm[2] : '0;
            r_out.norm_down_right <= is_track ? r_norm[3] : '0;
            r_out.horiz_error     <= is_track ? r_herr : '0;
            r_out.vert_error      <= is_track ? r_verr : '0;
            r_out.vert_move       <= v_move;
            r_out.horiz_move      <= h_move;
            r_out.cal_low_now     <= r_low[r_sel];
            r_out.cal_high_now    <= r_high[r_sel];
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.norm_top_left   = r_out.norm_top_left;
    assign o_out.norm_top_right  = r_out.norm_top_right;
    assign o_out.norm_down_left  = r_out.norm_down_left;
    assign o_out.norm_down_right = r_out.norm_down_right;
    assign o_out.horiz_error     = r_out.horiz_error;
    assign o_out.vert_error      = r_out.vert_error;
    assign o_out.vert_move       = r_out.vert_move;
    assign o_out.horiz_move      = r_out.horiz_move;
    assign o_out.cal_low_now     = r_out.cal_low_now;
    assign o_out.cal_high_now    = r_out.cal_high_now;

    // Checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in.ready)
        else $error("input ready while an item is in flight");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_pc) == qlte_pkg::PC_FIN)
        else $error("result raised outside the result step");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == qlte_pkg::PC_DIV && !r_empty) |-> r_rem < r_den)
        else $error("divider remainder not below divisor");

endmodule

`default_nettype wire
